>>> rtl/bsdm_pkg.sv
package bsdm_pkg;

    localparam int PIX_W     = 8;
    localparam int SUM_W     = 20;
    localparam int SQ_W      = 28;
    localparam int BS_W      = 7;
    localparam int OFF_W     = 6;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int DEV_W     = 15;
    localparam int ROW_W     = 11;
    localparam int COL_W     = 9;

    localparam int BS_MIN    = 2;
    localparam int BS_MAX    = 64;
    localparam int BS_RST    = 8;
    localparam int FW_RST    = 640;
    localparam int FH_RST    = 480;

    localparam int DEF_MAX_BLOCK_COLS = 512;
    localparam int DEF_MAX_FRAME_SIDE = 4096;

    // deviation datapath widths
    localparam int N_W   = 2 * BS_W - 1;        // block_size^2, up to 4096
    localparam int A_W   = N_W + SQ_W;          // n * sumsq
    localparam int B_W   = 2 * SUM_W;           // sum^2
    localparam int D_W   = 2 * N_W;             // n^2
    localparam int NUM_W = A_W + 16;            // (n*sumsq - sum^2) << 16
    localparam int Q_W   = 2 * DEV_W;           // quotient kept below 2^Q_W
    localparam int CNT_W = $clog2(Q_W);

    localparam logic [DEV_W-1:0] DEV_SAT = {DEV_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLOCK_SIZE   = 2'd0,
        REG_FRAME_WIDTH  = 2'd1,
        REG_FRAME_HEIGHT = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic in_blk;
        logic first;
        logic last;
        logic frame_done;
    } t_pos_flags;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  sq;
        logic [BS_W-1:0]  bs;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             done;
    } t_job;

endpackage

>>> rtl/block_stddev_map_unit.sv
// channel     | dir | transaction         | payload
// ------------+-----+---------------------+-------------------------------------------
// s_axis      | in  | one gray pixel      | tdata[7:0] pixel
// m_axis      | out | one finished block  | tdata deviation, block_row, block_col; tlast
// cfg         | in  | one register write  | i_cfg_index selects, i_cfg_data value
//
// a pixel is accepted with its memory read, then added and written back; no pixel is taken meanwhile
// a pixel that closes a block also waits until the deviation unit is free;
//   that unit squares, multiplies and subtracts, then divides, then takes the square root
// reset and every register write start a grid recompute of block position,
//   column count and row count, during which no pixel is taken
// a result waits in the output register while pixels keep flowing

module block_stddev_map_unit
    import bsdm_pkg::*;
#(
    parameter int MAX_BLOCK_COLS = DEF_MAX_BLOCK_COLS,
    parameter int MAX_FRAME_SIDE = DEF_MAX_FRAME_SIDE
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // pixel stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] pixel
    // block result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [39:0]          m_axis_tdata,   // [14:0] deviation, [25:15] block_row,
                                                 // [34:26] block_col, rest zero
    output logic                 m_axis_tlast    // frame_done
);

    localparam int FW = $clog2(MAX_FRAME_SIDE) + 1;
    localparam int PW = FW - 1;

    logic            pos_ready, acc_idle, dev_idle, accept;
    t_pos_flags      flags;
    logic [PW-1:0]   bx, by;
    logic [BS_W-1:0] bs;
    logic            job_valid;
    t_job            job;
    logic [DEV_W-1:0] dev;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;

    // a pixel closing a block needs the deviation unit free
    assign s_axis_tready = pos_ready && acc_idle && (!flags.last || dev_idle);
    assign accept        = s_axis_tvalid && s_axis_tready;

    bsdm_pos #(
        .MAX_BLOCK_COLS (MAX_BLOCK_COLS),
        .MAX_FRAME_SIDE (MAX_FRAME_SIDE),
        .FW             (FW),
        .PW             (PW)
    ) u_pos (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (accept),
        .o_ready     (pos_ready),
        .o_flags     (flags),
        .o_bx        (bx),
        .o_by        (by),
        .o_bs        (bs)
    );

    // column accumulators, read-modify-write
    bsdm_acc #(
        .MAX_BLOCK_COLS (MAX_BLOCK_COLS),
        .PW             (PW)
    ) u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_pixel     (s_axis_tdata[PIX_W-1:0]),
        .i_flags     (flags),
        .i_bx        (bx),
        .i_by        (by),
        .i_bs        (bs),
        .o_idle      (acc_idle),
        .o_job_valid (job_valid),
        .o_job       (job)
    );

    // variance, divide and square root
    bsdm_dev u_dev (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_idle      (dev_idle),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_dev       (dev),
        .o_row       (row),
        .o_col       (col),
        .o_done      (m_axis_tlast)
    );

    assign m_axis_tdata = {5'b0, col, row, dev};

endmodule

>>> rtl/bsdm_pos.sv
module bsdm_pos
    import bsdm_pkg::*;
#(
    parameter int MAX_BLOCK_COLS = DEF_MAX_BLOCK_COLS,
    parameter int MAX_FRAME_SIDE = DEF_MAX_FRAME_SIDE,
    parameter int FW             = $clog2(MAX_FRAME_SIDE) + 1,
    parameter int PW             = FW - 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_step,
    output logic                 o_ready,
    output t_pos_flags           o_flags,
    output logic [PW-1:0]        o_bx,
    output logic [PW-1:0]        o_by,
    output logic [BS_W-1:0]      o_bs
);

    localparam int CW   = (FW > CFG_W) ? FW : CFG_W;
    localparam int CNTW = $clog2(FW);

    logic [BS_W-1:0]  r_bs_reg;
    logic [CFG_W-1:0] r_fw_reg, r_fh_reg;
    logic [BS_W-1:0]  bs_c;
    logic [FW-1:0]    fw_c, fh_c;
    logic [CW-1:0]    fw_ext, fh_ext;

    logic [PW-1:0]    r_x, r_y, r_bx, r_by, r_cols, r_rows;
    logic [OFF_W-1:0] r_ox, r_oy;

    // shared restoring divider for the position / grid recompute
    logic             r_busy;
    logic [1:0]       r_phase;
    logic [CNTW-1:0]  r_cnt;
    logic [FW-1:0]    r_num, r_quo;
    logic [BS_W-1:0]  r_rem;
    logic [BS_W:0]    trial;
    logic             qbit;
    logic [BS_W-1:0]  n_rem;
    logic [FW-1:0]    n_quo;
    logic [FW-1:0]    next_operand;

    logic [FW-1:0]    x_inc, y_inc, y_cand;
    logic             x_wrap, y_zero, ox_wrap, oy_wrap;

    always_comb begin
        if (r_bs_reg < BS_W'(BS_MIN))      bs_c = BS_W'(BS_MIN);
        else if (r_bs_reg > BS_W'(BS_MAX)) bs_c = BS_W'(BS_MAX);
        else                               bs_c = r_bs_reg;
        fw_ext = CW'(r_fw_reg);
        fh_ext = CW'(r_fh_reg);
        if (fw_ext == '0)                       fw_c = FW'(1);
        else if (fw_ext > CW'(MAX_FRAME_SIDE))  fw_c = FW'(MAX_FRAME_SIDE);
        else                                    fw_c = FW'(fw_ext);
        if (fh_ext == '0)                       fh_c = FW'(1);
        else if (fh_ext > CW'(MAX_FRAME_SIDE))  fh_c = FW'(MAX_FRAME_SIDE);
        else                                    fh_c = FW'(fh_ext);
    end

    always_comb begin
        trial = {r_rem, r_num[FW-1]};
        qbit  = (trial >= (BS_W+1)'(bs_c));
        n_rem = qbit ? BS_W'(trial - (BS_W+1)'(bs_c)) : BS_W'(trial);
        n_quo = {r_quo[FW-2:0], qbit};
        case (r_phase)
            2'd0:    next_operand = FW'(r_y);
            2'd1:    next_operand = fw_c;
            2'd2:    next_operand = fh_c;
            default: next_operand = FW'(r_x);
        endcase
    end

    // raster step
    always_comb begin
        x_inc   = FW'(r_x) + FW'(1);
        x_wrap  = (x_inc >= fw_c);
        y_inc   = FW'(r_y) + FW'(1);
        y_cand  = x_wrap ? y_inc : FW'(r_y);
        y_zero  = (y_cand >= fh_c);
        ox_wrap = (BS_W'(r_ox) + BS_W'(1) == bs_c);
        oy_wrap = (BS_W'(r_oy) + BS_W'(1) == bs_c);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bs_reg <= BS_W'(BS_RST);
            r_fw_reg <= CFG_W'(FW_RST);
            r_fh_reg <= CFG_W'(FH_RST);
            r_x      <= '0;
            r_y      <= '0;
            r_busy   <= 1'b1;
            r_phase  <= '0;
            r_cnt    <= CNTW'(FW - 1);
            r_num    <= '0;
            r_rem    <= '0;
            r_quo    <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_BLOCK_SIZE:   r_bs_reg <= i_cfg_data[BS_W-1:0];
                REG_FRAME_WIDTH:  r_fw_reg <= i_cfg_data;
                REG_FRAME_HEIGHT: r_fh_reg <= i_cfg_data;
                default: ;
            endcase
            // restart the recompute with the pixel column
            r_busy  <= 1'b1;
            r_phase <= '0;
            r_cnt   <= CNTW'(FW - 1);
            r_num   <= FW'(r_x);
            r_rem   <= '0;
            r_quo   <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[FW-2:0], 1'b0};
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_cnt <= r_cnt - CNTW'(1);
            if (r_cnt == '0) begin
                case (r_phase)
                    2'd0: begin
                        r_bx <= n_quo[PW-1:0];
                        r_ox <= n_rem[OFF_W-1:0];
                    end
                    2'd1: begin
                        r_by <= n_quo[PW-1:0];
                        r_oy <= n_rem[OFF_W-1:0];
                    end
                    2'd2: begin
                        if (32'(n_quo) > 32'(MAX_BLOCK_COLS)) r_cols <= PW'(MAX_BLOCK_COLS);
                        else                                  r_cols <= n_quo[PW-1:0];
                    end
                    default: r_rows <= n_quo[PW-1:0];
                endcase
                r_phase <= r_phase + 2'd1;
                r_busy  <= (r_phase != 2'd3);
                r_cnt   <= CNTW'(FW - 1);
                r_num   <= next_operand;
                r_rem   <= '0;
                r_quo   <= '0;
            end
        end else if (i_step) begin
            if (x_wrap) begin
                r_x  <= '0;
                r_ox <= '0;
                r_bx <= '0;
            end else begin
                r_x  <= x_inc[PW-1:0];
                r_ox <= ox_wrap ? '0 : r_ox + OFF_W'(1);
                r_bx <= ox_wrap ? r_bx + PW'(1) : r_bx;
            end
            if (y_zero) begin
                r_y  <= '0;
                r_oy <= '0;
                r_by <= '0;
            end else if (x_wrap) begin
                r_y  <= y_cand[PW-1:0];
                r_oy <= oy_wrap ? '0 : r_oy + OFF_W'(1);
                r_by <= oy_wrap ? r_by + PW'(1) : r_by;
            end
        end
    end

    always_comb begin
        o_flags.in_blk     = (r_bx < r_cols) && (r_by < r_rows);
        o_flags.first      = (r_ox == '0) && (r_oy == '0);
        o_flags.last       = o_flags.in_blk && ox_wrap && oy_wrap;
        o_flags.frame_done = (r_by == r_rows - PW'(1)) && (r_bx == r_cols - PW'(1));
    end

    assign o_ready = !r_busy;
    assign o_bx    = r_bx;
    assign o_by    = r_by;
    assign o_bs    = bs_c;

endmodule

>>> rtl/bsdm_acc.sv
module bsdm_acc
    import bsdm_pkg::*;
#(
    parameter int MAX_BLOCK_COLS = DEF_MAX_BLOCK_COLS,
    parameter int PW             = $clog2(DEF_MAX_FRAME_SIDE)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [PIX_W-1:0] i_pixel,
    input  t_pos_flags       i_flags,
    input  logic [PW-1:0]    i_bx,
    input  logic [PW-1:0]    i_by,
    input  logic [BS_W-1:0]  i_bs,
    output logic             o_idle,
    output logic             o_job_valid,
    output t_job             o_job
);

    localparam int AW = (MAX_BLOCK_COLS > 1) ? $clog2(MAX_BLOCK_COLS) : 1;

    logic [SUM_W+SQ_W-1:0] mem [MAX_BLOCK_COLS];
    logic [SUM_W+SQ_W-1:0] r_rd;

    logic             r_busy;
    logic [PIX_W-1:0] r_pix;
    t_pos_flags       r_flags;
    logic [AW-1:0]    r_addr;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic [BS_W-1:0]  r_bs;

    logic [2*PIX_W-1:0] sq_pix;
    logic [SUM_W-1:0]   n_sum;
    logic [SQ_W-1:0]    n_sq;

    always_ff @(posedge i_clk) begin
        r_rd <= mem[AW'(i_bx)];
        if (r_busy && r_flags.in_blk) begin
            mem[r_addr] <= {n_sum, n_sq};
        end
    end

    always_comb begin
        sq_pix = r_pix * r_pix;
        if (r_flags.first) begin
            n_sum = SUM_W'(r_pix);
            n_sq  = SQ_W'(sq_pix);
        end else begin
            n_sum = r_rd[SUM_W+SQ_W-1:SQ_W] + SUM_W'(r_pix);
            n_sq  = r_rd[SQ_W-1:0] + SQ_W'(sq_pix);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= i_accept;
        end
        if (i_accept) begin
            r_pix   <= i_pixel;
            r_flags <= i_flags;
            r_addr  <= AW'(i_bx);
            r_row   <= ROW_W'(i_by);
            r_col   <= COL_W'(i_bx);
            r_bs    <= i_bs;
        end
    end

    assign o_idle      = !r_busy;
    assign o_job_valid = r_busy && r_flags.last;

    always_comb begin
        o_job.sum  = n_sum;
        o_job.sq   = n_sq;
        o_job.bs   = r_bs;
        o_job.row  = r_row;
        o_job.col  = r_col;
        o_job.done = r_flags.frame_done;
    end

endmodule

>>> rtl/bsdm_dev.sv
module bsdm_dev
    import bsdm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    input  t_job             i_job,
    output logic             o_idle,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [DEV_W-1:0] o_dev,
    output logic [ROW_W-1:0] o_row,
    output logic [COL_W-1:0] o_col,
    output logic             o_done
);

    typedef enum logic [2:0] {
        S_IDLE, S_SQUARE, S_PROD, S_DIFF, S_DIV, S_ROOT, S_OUT
    } t_state;

    t_state r_state, n_state;
    t_job   r_job, n_job;
    logic [N_W-1:0]   r_n, n_n;
    logic [A_W-1:0]   r_a, n_a;
    logic [B_W-1:0]   r_b, n_b;
    logic [D_W-1:0]   r_d, n_d;
    logic [NUM_W-1:0] r_rem, n_rem, r_ds, n_ds, num;
    logic [Q_W-1:0]   r_q, n_q, r_v, n_v, r_bit, n_bit;
    logic [Q_W:0]     r_root, n_root, trial;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DEV_W-1:0] r_res, n_res;
    logic             r_ov, n_ov;
    logic [DEV_W-1:0] r_odev, n_odev;
    logic [ROW_W-1:0] r_orow, n_orow;
    logic [COL_W-1:0] r_ocol, n_ocol;
    logic             r_odone, n_odone;

    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        n_n     = r_n;
        n_a     = r_a;
        n_b     = r_b;
        n_d     = r_d;
        n_rem   = r_rem;
        n_ds    = r_ds;
        n_q     = r_q;
        n_v     = r_v;
        n_bit   = r_bit;
        n_root  = r_root;
        n_cnt   = r_cnt;
        n_res   = r_res;
        n_ov    = r_ov && !i_ready;
        n_odev  = r_odev;
        n_orow  = r_orow;
        n_ocol  = r_ocol;
        n_odone = r_odone;
        num     = NUM_W'(r_a - A_W'(r_b)) << 16;
        trial   = r_root + (Q_W+1)'(r_bit);
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_job   = i_job;
                    n_state = S_SQUARE;
                end
            end
            S_SQUARE: begin
                n_n     = N_W'(r_job.bs) * N_W'(r_job.bs);
                n_state = S_PROD;
            end
            S_PROD: begin
                n_a     = A_W'(r_n) * A_W'(r_job.sq);
                n_b     = B_W'(r_job.sum) * B_W'(r_job.sum);
                n_d     = D_W'(r_n) * D_W'(r_n);
                n_state = S_DIFF;
            end
            S_DIFF: begin
                if (A_W'(r_b) >= r_a) begin
                    // negative or zero variance
                    n_res   = '0;
                    n_state = S_OUT;
                end else if (num >= (NUM_W'(r_d) << Q_W)) begin
                    n_res   = DEV_SAT;
                    n_state = S_OUT;
                end else begin
                    n_rem   = num;
                    n_ds    = NUM_W'(r_d) << (Q_W - 1);
                    n_q     = '0;
                    n_cnt   = CNT_W'(Q_W - 1);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_rem >= r_ds) begin
                    n_rem = r_rem - r_ds;
                    n_q   = {r_q[Q_W-2:0], 1'b1};
                end else begin
                    n_q   = {r_q[Q_W-2:0], 1'b0};
                end
                n_ds  = r_ds >> 1;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_v     = n_q;
                    n_root  = '0;
                    n_bit   = Q_W'(1) << (Q_W - 2);
                    n_cnt   = CNT_W'(Q_W / 2 - 1);
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                if ((Q_W+1)'(r_v) >= trial) begin
                    n_v    = r_v - Q_W'(trial);
                    n_root = (r_root >> 1) + (Q_W+1)'(r_bit);
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit = r_bit >> 2;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_res   = n_root[DEV_W-1:0];
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ov || i_ready) begin
                    n_ov    = 1'b1;
                    n_odev  = r_res;
                    n_orow  = r_job.row;
                    n_ocol  = r_job.col;
                    n_odone = r_job.done;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
        r_job   <= n_job;
        r_n     <= n_n;
        r_a     <= n_a;
        r_b     <= n_b;
        r_d     <= n_d;
        r_rem   <= n_rem;
        r_ds    <= n_ds;
        r_q     <= n_q;
        r_v     <= n_v;
        r_bit   <= n_bit;
        r_root  <= n_root;
        r_cnt   <= n_cnt;
        r_res   <= n_res;
        r_odev  <= n_odev;
        r_orow  <= n_orow;
        r_ocol  <= n_ocol;
        r_odone <= n_odone;
    end

    assign o_idle  = (r_state == S_IDLE);
    assign o_valid = r_ov;
    assign o_dev   = r_odev;
    assign o_row   = r_orow;
    assign o_col   = r_ocol;
    assign o_done  = r_odone;

endmodule

>>> tb/sv/block_stddev_map_unit_test.sv
`timescale 1ns / 100ps

module block_stddev_map_unit_test;
    import bsdm_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    // deviation unit, grid recompute and output stall, with margin
    localparam int DRAIN_CYCLES   = 200;
    localparam int RANDOM_PIXELS  = 1100;
    localparam int CALM_AFTER     = 900;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum int {PAT_ZERO, PAT_FULL, PAT_CHECKER, PAT_NOISE} t_pattern;

    typedef struct {
        int unsigned bs;
        int unsigned fw;
        int unsigned fh;
        t_pattern    pat;
        int          dev;    // typed deviation of every block, -1 when predicted
    } t_frame_row;

    typedef struct packed {
        logic [DEV_W-1:0] deviation;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             done;
    } t_block_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata;   // [7:0] pixel
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [39:0]          m_axis_tdata;   // [14:0] deviation, [25:15] block_row, [34:26] block_col
    logic                 m_axis_tlast;   // frame_done

    block_stddev_map_unit DUT (.*);

    // predictor state: registers as written, position and column accumulators
    int unsigned   blk_size_reg, width_reg, height_reg;
    int unsigned   pos_x, pos_y;
    int unsigned   col_sum [DEF_MAX_BLOCK_COLS];
    int unsigned   col_sq  [DEF_MAX_BLOCK_COLS];

    t_block_result pending_blocks[$];
    int            forced_dev;       // typed expectation for directed rows
    bit            failed;
    bit            calm;             // no idling on either side
    int            random_sent;
    int            out_stall;
    int            idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // floor(sqrt(floor(65536 * (n*sq - s^2) / n^2))), saturated
    function automatic logic [DEV_W-1:0] block_deviation(int unsigned s, int unsigned sq,
                                                         int unsigned n);
        longint unsigned a, b, q, root, cand;
        a = longint'(n) * sq;
        b = longint'(s) * s;
        if (b >= a) return '0;
        q = ((a - b) << 16) / (longint'(n) * n);
        root = 0;
        for (int i = 31; i >= 0; i--) begin
            cand = root | (64'd1 << i);
            if (cand * cand <= q) root = cand;
        end
        return (root > 32767) ? DEV_SAT : root[DEV_W-1:0];
    endfunction

    // advance the pixel position and update the column sums for one pixel
    task automatic account_pixel(input logic [7:0] pix);
        int unsigned bs, fw, fh, cols, rows, bx, by, ox, oy;
        t_block_result r;
        bs = clampu(blk_size_reg, BS_MIN, BS_MAX);
        fw = clampu(width_reg, 1, DEF_MAX_FRAME_SIDE);
        fh = clampu(height_reg, 1, DEF_MAX_FRAME_SIDE);
        cols = fw / bs;
        rows = fh / bs;
        if (cols > DEF_MAX_BLOCK_COLS) cols = DEF_MAX_BLOCK_COLS;
        bx = pos_x / bs;
        by = pos_y / bs;
        ox = pos_x % bs;
        oy = pos_y % bs;
        if (bx < cols && by < rows) begin
            if (ox == 0 && oy == 0) begin
                col_sum[bx] = pix;
                col_sq[bx]  = pix * pix;
            end else begin
                col_sum[bx] = (col_sum[bx] + pix) & 32'hFFFFF;
                col_sq[bx]  = (col_sq[bx] + pix * pix) & 32'hFFFFFFF;
            end
            if (ox == bs - 1 && oy == bs - 1) begin
                r.deviation = block_deviation(col_sum[bx], col_sq[bx], bs * bs);
                if (forced_dev >= 0) r.deviation = DEV_W'(forced_dev);
                r.row  = by[ROW_W-1:0];
                r.col  = bx[COL_W-1:0];
                r.done = (by == rows - 1 && bx == cols - 1);
                pending_blocks.push_back(r);
            end
        end
        pos_x++;
        if (pos_x >= fw) begin
            pos_x = 0;
            pos_y++;
        end
        if (pos_y >= fh) pos_y = 0;
    endtask

    // register write, only once the block has gone quiet
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        while (pending_blocks.size() != 0) @(posedge i_clk);
        repeat (160) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_BLOCK_SIZE:   blk_size_reg = value & 32'h7F;
            REG_FRAME_WIDTH:  width_reg    = value & 32'h1FFF;
            REG_FRAME_HEIGHT: height_reg   = value & 32'h1FFF;
            default: ;
        endcase
    endtask

    // one pixel transaction; tvalid stays high between back-to-back pixels
    task automatic send_pixel(input logic [7:0] pix);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        do @(posedge i_clk); while (!s_axis_tready);
        account_pixel(pix);
    endtask

    function automatic logic [7:0] pattern_pixel(t_pattern pat, int unsigned k, int unsigned fw);
        case (pat)
            PAT_ZERO:    return 8'd0;
            PAT_FULL:    return 8'd255;
            PAT_CHECKER: return (((k % fw) + (k / fw)) % 2 == 1) ? 8'd255 : 8'd0;
            default:     return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic run_frame(input t_frame_row fr, input int unsigned count);
        int unsigned fw;
        write_reg(REG_BLOCK_SIZE, fr.bs);
        write_reg(REG_FRAME_WIDTH, fr.fw);
        write_reg(REG_FRAME_HEIGHT, fr.fh);
        fw = clampu(width_reg, 1, DEF_MAX_FRAME_SIDE);
        forced_dev = fr.dev;
        for (int unsigned k = 0; k < count; k++)
            send_pixel(pattern_pixel(fr.pat, k, fw));
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        forced_dev = -1;
    endtask

    // result side: random stall bursts on tready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            out_stall     <= 0;
        end else if (out_stall > 0) begin
            out_stall     <= out_stall - 1;
            m_axis_tready <= (out_stall == 1);
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            out_stall     <= $urandom_range(1, 13);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // result checker: each block result against the oldest expectation
    always @(posedge i_clk) begin
        t_block_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.deviation = m_axis_tdata[14:0];
            got.row       = m_axis_tdata[25:15];
            got.col       = m_axis_tdata[34:26];
            got.done      = m_axis_tlast;
            if (pending_blocks.size() == 0) begin
                $display("%0t unexpected block result dev=%0d row=%0d col=%0d done=%0d",
                         $time, got.deviation, got.row, got.col, got.done);
                failed = 1'b1;
            end else begin
                want = pending_blocks.pop_front();
                if (got.deviation !== want.deviation) begin
                    $display("%0t deviation: expected %0d actual %0d",
                             $time, want.deviation, got.deviation);
                    failed = 1'b1;
                end
                if (got.row !== want.row) begin
                    $display("%0t block_row: expected %0d actual %0d", $time, want.row, got.row);
                    failed = 1'b1;
                end
                if (got.col !== want.col) begin
                    $display("%0t block_col: expected %0d actual %0d", $time, want.col, got.col);
                    failed = 1'b1;
                end
                if (got.done !== want.done) begin
                    $display("%0t frame_done: expected %0d actual %0d",
                             $time, want.done, got.done);
                    failed = 1'b1;
                end
            end
        end
    end

    // watchdog on cycles with no transaction anywhere
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // directed frames; checker blocks with an even side are half 0 and half 255,
    // so the deviation is exactly 127.5
    t_frame_row directed_frames[] = '{
        '{2,    2,    2,  PAT_CHECKER, 32640},
        '{2,    2,    2,  PAT_FULL,    0},
        '{8,    8,    8,  PAT_ZERO,    0},
        '{8,    8,    8,  PAT_CHECKER, 32640},
        '{8,    4,    4,  PAT_NOISE,   -1},   // frame smaller than a block
        '{1,    5,    3,  PAT_NOISE,   -1},   // side below range, partial edges
        '{127,  130,  2,  PAT_NOISE,   -1},   // side above range
        '{0,    0,    0,  PAT_NOISE,   -1},   // 1x1 frame
        '{2,    68,   2,  PAT_NOISE,   -1},   // starts every column the random part reaches
        '{3,    9,    9,  PAT_FULL,    0}
    };

    initial begin
        t_frame_row fr;
        int unsigned n;
        failed = 1'b0;
        calm = 1'b0;
        forced_dev = -1;
        random_sent = 0;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_BLOCK_SIZE;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        blk_size_reg = BS_RST;
        width_reg = FW_RST;
        height_reg = FH_RST;
        pos_x = 0;
        pos_y = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_frames[i]) begin
            fr = directed_frames[i];
            run_frame(fr, clampu(fr.fw, 1, DEF_MAX_FRAME_SIDE) *
                          clampu(fr.fh, 1, DEF_MAX_FRAME_SIDE));
        end
        // an unused register index must change nothing
        write_reg(REG_UNUSED, 8191);

        // every column entry the random part can reach is written by now,
        // so mid-frame changes are safe
        while (random_sent < RANDOM_PIXELS) begin
            if (random_sent >= CALM_AFTER) calm = 1'b1;
            case ($urandom_range(0, 9))
                0: begin
                    fr.bs = $urandom_range(0, 1) ? 64 : $urandom_range(0, 127);
                    fr.fw = 64 + $urandom_range(0, 3);
                    fr.fh = 64;
                end
                1: begin
                    fr.bs = $urandom_range(2, 4);
                    fr.fw = $urandom_range(0, 12);
                    fr.fh = $urandom_range(0, 1) ? 4096 : 8191;   // tallest frames
                end
                default: begin
                    fr.bs = $urandom_range(2, 6);
                    fr.fw = fr.bs * $urandom_range(1, 5) + $urandom_range(0, fr.bs);
                    fr.fh = fr.bs * $urandom_range(1, 3) + $urandom_range(0, fr.bs);
                end
            endcase
            fr.pat = ($urandom_range(0, 9) == 0) ? t_pattern'($urandom_range(0, 2)) : PAT_NOISE;
            fr.dev = -1;
            n = clampu(fr.fw, 1, DEF_MAX_FRAME_SIDE) * clampu(fr.fh, 1, DEF_MAX_FRAME_SIDE);
            if (n > 600 || $urandom_range(0, 4) == 0)
                n = $urandom_range(1, (n > 600) ? 600 : n);   // stop mid-frame
            if ($urandom_range(0, 5) == 0) begin
                // change one register only, keeping the current position
                write_reg(t_reg_idx'($urandom_range(0, 2)), $urandom_range(0, 40));
                for (int unsigned k = 0; k < n && k < 200; k++) begin
                    send_pixel(8'($urandom_range(0, 255)));
                    random_sent++;
                end
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end else begin
                run_frame(fr, n);
                random_sent += n;
            end
        end

        while (pending_blocks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (!failed && pending_blocks.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> sim.f
rtl/bsdm_pkg.sv
rtl/bsdm_pos.sv
rtl/bsdm_acc.sv
rtl/bsdm_dev.sv
rtl/block_stddev_map_unit.sv
tb/sv/block_stddev_map_unit_test.sv
